>>> rtl/fsi_pkg.sv
// ----------------------------------------------------------------------------
// fsi_pkg: shared constants and types for the fftshift index block
// Register map, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package fsi_pkg;

  // Field widths fixed by the block's interface.
  localparam int SizeBits  = 17;
  localparam int OutBits   = 32;
  localparam int InBits    = 32;
  localparam int DataBits  = 32;
  localparam int NumRegs   = 4;
  localparam int AddrBits  = 4;

  // Parameter defaults.
  localparam int DefMaxDims   = 4;
  localparam int DefIndexBits = 32;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_SIZE_DIM0 = 2'd0,
    REG_SIZE_DIM1 = 2'd1,
    REG_SIZE_DIM2 = 2'd2,
    REG_SIZE_DIM3 = 2'd3
  } reg_idx_t;

endpackage

>>> rtl/fsi_split.sv
// ----------------------------------------------------------------------------
// fsi_split: coordinate extraction pipeline
// Restoring division, one quotient bit per stage, innermost dimension first.
// ----------------------------------------------------------------------------
module fsi_split
  import fsi_pkg::*;
#(
  parameter int MAX_DIMS   = DefMaxDims,
  parameter int INDEX_BITS = DefIndexBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic [MAX_DIMS-1:0][SizeBits-1:0]    sizes,
  input  logic                                 in_v,
  input  logic [INDEX_BITS-1:0]                in_idx,
  output logic                                 out_v,
  output logic [INDEX_BITS-1:0]                out_quot,
  output logic [MAX_DIMS-1:0][SizeBits-1:0]    out_coord
);

  localparam int NumStages = MAX_DIMS * INDEX_BITS;

  logic [NumStages-1:0]                v_r;
  logic [INDEX_BITS-1:0]               q_r [NumStages];
  logic [SizeBits-1:0]                 r_r [NumStages];
  logic [MAX_DIMS-1:0][SizeBits-1:0]   c_r [NumStages];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    localparam int D = MAX_DIMS - 1 - (k / INDEX_BITS);
    localparam int B = INDEX_BITS - 1 - (k % INDEX_BITS);

    logic                              v_in;
    logic [INDEX_BITS-1:0]             q_in;
    logic [SizeBits-1:0]               r_in;
    logic [MAX_DIMS-1:0][SizeBits-1:0] c_in;
    logic [SizeBits:0]                 trial;
    logic [SizeBits:0]                 diff;
    logic                              ge;
    logic [INDEX_BITS-1:0]             q_new;
    logic [SizeBits-1:0]               r_new;
    logic [MAX_DIMS-1:0][SizeBits-1:0] c_new;

    // Select the previous stage, or the input beat for the first one.
    if (k == 0) begin : g_first
      assign v_in = in_v;
      assign q_in = in_idx;
      assign c_in = '0;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign q_in = q_r[k-1];
      assign c_in = c_r[k-1];
    end

    // A new dimension starts with an empty partial remainder.
    if (B == INDEX_BITS - 1) begin : g_r0
      assign r_in = '0;
    end else begin : g_rn
      assign r_in = r_r[k-1];
    end

    // One restoring step: shift in a dividend bit, compare and subtract.
    always_comb begin
      trial = {r_in, q_in[B]};
      diff  = trial - {1'b0, sizes[D]};
      ge    = (trial >= {1'b0, sizes[D]});
      r_new = ge ? diff[SizeBits-1:0] : trial[SizeBits-1:0];
      q_new = q_in;
      q_new[B] = ge;
      c_new = c_in;
      if (B == 0) begin
        c_new[D] = r_new;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_new;
        r_r[k] <= r_new;
        c_r[k] <= c_new;
      end
    end
  end

  assign out_v     = v_r[NumStages-1];
  assign out_quot  = q_r[NumStages-1];
  assign out_coord = c_r[NumStages-1];

endmodule

>>> rtl/fsi_merge.sv
// ----------------------------------------------------------------------------
// fsi_merge: coordinate shift and row-major recombination
// Adds half of each size with wrap, then folds coordinates by Horner's rule.
// ----------------------------------------------------------------------------
module fsi_merge
  import fsi_pkg::*;
#(
  parameter int MAX_DIMS   = DefMaxDims,
  parameter int INDEX_BITS = DefIndexBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic [MAX_DIMS-1:0][SizeBits-1:0]    sizes,
  input  logic                                 in_v,
  input  logic [INDEX_BITS-1:0]                in_quot,
  input  logic [MAX_DIMS-1:0][SizeBits-1:0]    in_coord,
  output logic                                 out_v,
  output logic [OutBits-1:0]                   out_index,
  output logic                                 out_oor
);

  localparam int NumStages = 2 * (MAX_DIMS - 1) + 1;

  logic [NumStages-1:0]                v_r;
  logic [NumStages-1:0]                oor_r;
  logic [INDEX_BITS-1:0]               acc_r [NumStages];
  logic [MAX_DIMS-1:0][SizeBits-1:0]   sc_r  [NumStages];

  logic                              any_zero;
  logic [MAX_DIMS-1:0][SizeBits-1:0] sc0;
  logic [INDEX_BITS+SizeBits-1:0]    acc_ext0;

  // Shift each coordinate by half its size, wrapping once.
  always_comb begin
    any_zero = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      logic [SizeBits:0] sum;
      sum = {1'b0, in_coord[d]} + {2'b00, sizes[d][SizeBits-1:1]};
      if (sum >= {1'b0, sizes[d]}) begin
        sum = sum - {1'b0, sizes[d]};
      end
      sc0[d] = sum[SizeBits-1:0];
      if (sizes[d] == '0) begin
        any_zero = 1'b1;
      end
    end
    acc_ext0 = {{INDEX_BITS{1'b0}}, sc0[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  // The index is in range only when the final quotient is zero.
  always_ff @(posedge clk) begin
    if (en) begin
      oor_r[0] <= any_zero || (in_quot != '0);
      sc_r[0]  <= sc0;
      acc_r[0] <= acc_ext0[INDEX_BITS-1:0];
    end
  end

  for (genvar j = 1; j < NumStages; j++) begin : g_fold
    localparam int D = (j + 1) / 2;
    logic [INDEX_BITS+SizeBits-1:0] res;

    // Odd stages multiply by the next size; even stages add the coordinate.
    if (j % 2 == 1) begin : g_mul
      assign res = acc_r[j-1] * sizes[D];
    end else begin : g_add
      assign res = {{SizeBits{1'b0}}, acc_r[j-1]}
                 + {{INDEX_BITS{1'b0}}, sc_r[j-1][D]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        oor_r[j] <= oor_r[j-1];
        sc_r[j]  <= sc_r[j-1];
        acc_r[j] <= res[INDEX_BITS-1:0];
      end
    end
  end

  logic [OutBits+INDEX_BITS-1:0] acc_wide;

  // Zero the index when out of range and fit it to the output width.
  always_comb begin
    acc_wide = {{OutBits{1'b0}}, acc_r[NumStages-1]};
    if (oor_r[NumStages-1]) begin
      acc_wide = '0;
    end
  end

  assign out_v     = v_r[NumStages-1];
  assign out_oor   = oor_r[NumStages-1];
  assign out_index = acc_wide[OutBits-1:0];

endmodule

>>> rtl/fsi_out_skid.sv
// ----------------------------------------------------------------------------
// fsi_out_skid: output register with one skid entry
// Holds a finished beat that meets a receiver stall, then halts the pipeline.
// ----------------------------------------------------------------------------
module fsi_out_skid
  import fsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_v,
  input  logic [OutBits-1:0] in_index,
  input  logic               in_oor,
  output logic               pipe_en,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OutBits-1:0] out_index,
  output logic               out_oor
);

  logic               skid_v;
  logic [OutBits-1:0] skid_index;
  logic               skid_oor;
  logic               out_free;

  assign out_free = !out_valid || out_ready;
  assign pipe_en  = !skid_v;

  // Control: output and skid occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_free) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end
    end else if (in_v) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload moves along with the control above.
  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_free) begin
        out_index <= skid_index;
        out_oor   <= skid_oor;
      end
    end else if (in_v) begin
      if (out_free) begin
        out_index <= in_index;
        out_oor   <= in_oor;
      end else begin
        skid_index <= in_index;
        skid_oor   <= in_oor;
      end
    end
  end

endmodule

>>> rtl/fft_shift_index_nd_core.sv
// ----------------------------------------------------------------------------
// fft_shift_index_nd_core: fftshift address generator for up to N dimensions
// Maps a row-major linear index to its half-size cyclically shifted index.
// ----------------------------------------------------------------------------
// Usage:
// Load the dimension sizes through the APB port (size_dim0 outermost at
// address 0, size_dim3 innermost at address 12); unused dimensions keep 1.
// Change sizes only while no beat is in flight.
// Input beats carry linear_index on in_valid/in_ready; result beats carry
// shifted_index and out_of_range on out_valid/out_ready. An index not below
// the product of the sizes, or any size of zero, gives out_of_range = 1 and
// shifted_index = 0.
// Throughput is one beat per clock while the skid entry is empty. The
// division pipeline retires one quotient bit per stage per dimension, and
// the fold takes a multiply and an add stage per dimension after the first,
// plus the shift stage and the output register.
// Reset clears all valid bits and sets every size to 1.
// When the receiver stalls, one more beat lands in a skid entry and then
// in_ready drops and the whole pipeline holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fft_shift_index_nd_core
  import fsi_pkg::*;
#(
  parameter int MAX_DIMS   = DefMaxDims,
  parameter int INDEX_BITS = DefIndexBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [InBits-1:0]   linear_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OutBits-1:0]  shifted_index,
  output logic                out_of_range
);

  logic [MAX_DIMS-1:0][SizeBits-1:0] sizes;
  logic                              wr_en;
  reg_idx_t                          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[AddrBits-1:2]);

  // Size registers; dimensions beyond the register map stay at 1.
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_size
    if (d < NumRegs) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          sizes[d] <= SizeBits'(1);
        end else if (wr_en && (reg_idx == reg_idx_t'(d))) begin
          sizes[d] <= pwdata[SizeBits-1:0];
        end
      end
    end else begin : g_fixed
      assign sizes[d] = SizeBits'(1);
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if ((d < NumRegs) && (reg_idx == reg_idx_t'(d))) begin
        prdata = {{(DataBits-SizeBits){1'b0}}, sizes[d]};
      end
    end
  end

  // Fit the input index to the internal index width.
  logic [INDEX_BITS+InBits-1:0] idx_wide;
  logic [INDEX_BITS-1:0]        idx;
  assign idx_wide = {{INDEX_BITS{1'b0}}, linear_index};
  assign idx      = idx_wide[INDEX_BITS-1:0];

  logic                              pipe_en;
  logic                              sp_v;
  logic [INDEX_BITS-1:0]             sp_quot;
  logic [MAX_DIMS-1:0][SizeBits-1:0] sp_coord;
  logic                              mg_v;
  logic [OutBits-1:0]                mg_index;
  logic                              mg_oor;

  assign in_ready = pipe_en;

  fsi_split #(
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (INDEX_BITS)
  ) u_split (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .sizes     (sizes),
    .in_v      (in_valid && pipe_en),
    .in_idx    (idx),
    .out_v     (sp_v),
    .out_quot  (sp_quot),
    .out_coord (sp_coord)
  );

  fsi_merge #(
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (INDEX_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .sizes     (sizes),
    .in_v      (sp_v),
    .in_quot   (sp_quot),
    .in_coord  (sp_coord),
    .out_v     (mg_v),
    .out_index (mg_index),
    .out_oor   (mg_oor)
  );

  fsi_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_v      (mg_v && pipe_en),
    .in_index  (mg_index),
    .in_oor    (mg_oor),
    .pipe_en   (pipe_en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (shifted_index),
    .out_oor   (out_of_range)
  );

`ifndef SYNTHESIS
  // An out-of-range result always carries a zero index.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> shifted_index == '0)
    else $error("out_of_range result with nonzero index");

  // Reset empties the output and skid entries.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // Input is refused only while a result is held back by the receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A refused input follows a cycle in which the receiver stalled.
  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stall without receiver stall");
`endif

endmodule

>>> dv/tb_fft_shift_index_nd_core.sv
// ----------------------------------------------------------------------------
// tb_fft_shift_index_nd_core: self-checking bench for the fftshift index block
// Loads dimension sizes over APB, sends linear indexes under several idle
// patterns, predicts each shifted index and compares every result beat.
// ----------------------------------------------------------------------------
module tb_fft_shift_index_nd_core;
  import fsi_pkg::*;

  localparam int Latency    = 136;
  localparam int CycleLimit = 1500000;

  typedef struct packed {
    logic [OutBits-1:0] idx;
    logic               oor;
  } shift_res_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [DataBits-1:0] pwdata;
  logic [DataBits-1:0] prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [InBits-1:0]   linear_index;
  logic                out_valid;
  logic                out_ready;
  logic [OutBits-1:0]  shifted_index;
  logic                out_of_range;

  // Model copy of the size registers and the expected result beats.
  logic [SizeBits-1:0] dim_sizes [NumRegs];
  shift_res_t          pending_shifts [$];
  int                  error_count;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  hold_cycles;
  longint              cycle_count;

  fft_shift_index_nd_core dut (.*);

  // Clock with a period of 2 time units.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Compute the expected shifted index for the current sizes.
  function automatic shift_res_t predict_shift(logic [InBits-1:0] lin);
    shift_res_t r;
    logic [63:0] prod;
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] stride;
    logic [63:0] s;
    logic [63:0] c;
    logic [127:0] wide;
    prod = 64'd1;
    for (int d = 0; d < NumRegs; d++) begin
      wide = prod * 128'(dim_sizes[d]);
      prod = (wide[127:64] != 0) ? '1 : wide[63:0];
    end
    r = '0;
    if (64'(lin) >= prod) begin
      r.oor = 1'b1;
      return r;
    end
    rem    = 64'(lin);
    acc    = 0;
    stride = 1;
    for (int d = NumRegs - 1; d >= 0; d--) begin
      s   = 64'(dim_sizes[d]);
      c   = rem % s;
      rem = rem / s;
      c   = c + s / 2;
      if (c >= s) begin
        c = c - s;
      end
      acc    = acc + c * stride;
      stride = stride * s;
    end
    r.idx = acc[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // APB write of one size register.
  task automatic write_size(reg_idx_t which, logic [DataBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrBits'(4 * int'(which));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dim_sizes[which] = value[SizeBits-1:0];
  endtask

  task automatic set_sizes(int s0, int s1, int s2, int s3);
    write_size(REG_SIZE_DIM0, s0);
    write_size(REG_SIZE_DIM1, s1);
    write_size(REG_SIZE_DIM2, s2);
    write_size(REG_SIZE_DIM3, s3);
  endtask

  // Send one index beat, with a random idle gap before it.
  task automatic send_index(logic [InBits-1:0] lin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    linear_index <= lin;
    pending_shifts.push_back(predict_shift(lin));
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Wait until every expected beat is back, then let the pipeline drain.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_shifts.size() != 0) begin
      @(posedge clk);
    end
    repeat (Latency + 10) @(posedge clk);
  endtask

  // Random index: mostly inside the array, sometimes at or past its end.
  function automatic logic [InBits-1:0] pick_index();
    longint p;
    p = 1;
    for (int d = 0; d < NumRegs; d++) begin
      p = p * dim_sizes[d];
    end
    case ($urandom_range(9))
      0: return $urandom();
      1: return (p <= 64'hFFFF_FFFF) ? InBits'(p) : $urandom();
      2: return (p > 0 && p <= 64'h1_0000_0000) ? InBits'(p - 1) : '1;
      default: begin
        if (p == 0) begin
          return $urandom();
        end
        if (p > 64'hFFFF_FFFF) begin
          return $urandom();
        end
        return InBits'(longint'({$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF_FFFF) % p);
      end
    endcase
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      send_index(pick_index());
    end
  endtask

  function automatic int rand_size();
    case ($urandom_range(5))
      0: return 1;
      1: return $urandom_range(2, 3);
      2: return 65536;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Directed: reset sizes, field extremes, odd and even sizes, zero size.
  task automatic test_directed();
    send_index(0);
    send_index(1);
    send_index('1);
    drain_results();
    set_sizes(3, 4, 5, 6);
    for (int i = 0; i < 8; i++) begin
      send_index(i);
    end
    send_index(359);
    send_index(360);
    send_index(32'h8000_0000);
    drain_results();
    set_sizes(0, 4, 4, 4);
    send_index(0);
    send_index(5);
    drain_results();
    set_sizes(65536, 65536, 1, 1);
    send_index('1);
    send_index(32'hAAAA_5555);
    drain_results();
    set_sizes(131071, 131071, 131071, 131071);
    send_index('1);
    send_index(32'h5555_AAAA);
    drain_results();
  endtask

  // Random sizes and indexes under a given idle pattern.
  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 4; k++) begin
      set_sizes(rand_size(), rand_size(), rand_size(), rand_size());
      run_random(count / 4);
      drain_results();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_sizes(7, 8, 9, 10);
    hold_cycles = 400;
    run_random(300);
    drain_results();
  endtask

  // Receiver: random stalls plus a counted hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    shift_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_shifts.size() == 0) begin
        report_mismatch("unexpected beat", 64'(shifted_index), 64'd0);
      end else begin
        want = pending_shifts.pop_front();
        if (shifted_index !== want.idx) begin
          report_mismatch("shifted_index", 64'(shifted_index), 64'(want.idx));
        end
        if (out_of_range !== want.oor) begin
          report_mismatch("out_of_range", 64'(out_of_range), 64'(want.oor));
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    linear_index   = '0;
    error_count    = 0;
    cycle_count    = 0;
    hold_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int d = 0; d < NumRegs; d++) begin
      dim_sizes[d] = 1;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 320);
    test_random_phase(50, 0, 240);
    test_random_phase(0, 50, 240);
    test_random_phase(35, 35, 200);
    test_backpressure();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
